@@ src/m3i_pkg.sv @@
// m3i_pkg: shared types and constants for the 3x3 matrix inverse pipeline
// used by m3i_divider and matrix3_inverse; no dependencies
package m3i_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ELEM_W        = 32;
  localparam int N_ELEM        = 9;
  localparam int EPS_W         = 31;
  localparam int PROD_W        = 64;
  localparam int ADJ_W         = 65;
  localparam int DET_W         = 98;
  localparam int DIV_W         = 130;
  // quotient bits 31..0 plus one overflow bit
  localparam int QUO_W         = 33;

  localparam logic [QUO_W-1:0]  QUO_POS_MAX = 33'h07fffffff;
  localparam logic [QUO_W-1:0]  QUO_NEG_MAX = 33'h080000000;
  localparam logic [ELEM_W-1:0] SAT_POS     = 32'h7fffffff;
  localparam logic [ELEM_W-1:0] SAT_NEG     = 32'h80000000;

  typedef logic [3:0] idx_t;

  // adjugate entry k = e[i0]*e[i1] - e[i2]*e[i3], elements row-major
  localparam idx_t ADJ_IDX [N_ELEM][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  // cofactors of the first row
  localparam idx_t COF_IDX [3] = '{4'd0, 4'd3, 4'd6};

  typedef struct packed {
    logic              valid;
    logic              singular;
    logic [N_ELEM-1:0] neg;
  } side_t;

endpackage

@@ src/m3i_divider.sv @@
// m3i_divider: nine-lane pipelined restoring divider, one quotient bit per stage
// depends on m3i_pkg
module m3i_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [m3i_pkg::DIV_W-1:0] num_i [m3i_pkg::N_ELEM],
  input  logic [m3i_pkg::DIV_W-1:0] den_i,
  input  m3i_pkg::side_t            side_i,
  output logic [m3i_pkg::QUO_W-1:0] quo_o [m3i_pkg::N_ELEM],
  output m3i_pkg::side_t            side_o
);
  import m3i_pkg::*;

  logic [DIV_W-1:0] rem_r  [QUO_W][N_ELEM];
  logic [DIV_W-1:0] den_r  [QUO_W];
  logic [QUO_W-1:0] quo_r  [QUO_W][N_ELEM];
  side_t            side_r [QUO_W];

  genvar s, l;
  generate
    for (s = 0; s < QUO_W; s++) begin : g_stage
      localparam int B = QUO_W - 1 - s;
      logic [DIV_W-1:0] den_in;
      side_t            side_in;

      if (s == 0) begin : g_first
        assign den_in  = den_i;
        assign side_in = side_i;
      end else begin : g_next
        assign den_in  = den_r[s-1];
        assign side_in = side_r[s-1];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          side_r[s].valid <= 1'b0;
        end else if (en) begin
          side_r[s].valid <= side_in.valid;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          den_r[s]           <= den_in;
          side_r[s].singular <= side_in.singular;
          side_r[s].neg      <= side_in.neg;
        end
      end

      for (l = 0; l < N_ELEM; l++) begin : g_lane
        logic [DIV_W-1:0] rem_in;
        logic [QUO_W-1:0] quo_in;
        logic [DIV_W-1:0] den_sh;
        logic             take;

        if (s == 0) begin : g_first
          assign rem_in = num_i[l];
          assign quo_in = '0;
        end else begin : g_next
          assign rem_in = rem_r[s-1][l];
          assign quo_in = quo_r[s-1][l];
        end

        assign den_sh = den_in << B;
        assign take   = (rem_in >= den_sh);

        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[s][l] <= take ? (rem_in - den_sh) : rem_in;
            quo_r[s][l] <= {quo_in[QUO_W-2:0], take};
          end
        end
      end
    end

    for (l = 0; l < N_ELEM; l++) begin : g_out
      assign quo_o[l] = quo_r[QUO_W-1][l];
    end
  endgenerate

  assign side_o = side_r[QUO_W-1];

endmodule

@@ src/matrix3_inverse.sv @@
// matrix3_inverse: one 3x3 Q16.16 matrix is accepted per clock while the result side
// does not stall, and its inverse passes through five stages for minors, determinant and
// threshold test, 33 divider stages and one output register; a stall on the result side freezes the whole pipeline.
// depends on m3i_pkg and m3i_divider
module matrix3_inverse #(
  parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [m3i_pkg::EPS_W-1:0] cfg_wr_data,  // det_epsilon
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [287:0]              in_tdata,     // a00,a01,a02,a10,a11,a12,a20,a21,a22
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [287:0]              out_tdata,    // r00,r01,r02,r10,r11,r12,r20,r21,r22
  output logic [1:0]                out_tuser     // singular, saturated
);
  import m3i_pkg::*;

  logic             en;
  logic [EPS_W-1:0] eps_r;

  logic signed [ELEM_W-1:0] e [N_ELEM];

  logic                     v1_r, v2_r, v3_r, v4_r;
  logic signed [PROD_W-1:0] prod_r [2*N_ELEM];
  logic signed [ELEM_W-1:0] row_s1_r [3];
  logic signed [ELEM_W-1:0] row_s2_r [3];
  logic signed [ADJ_W-1:0]  adj_s2_r [N_ELEM];
  logic signed [ADJ_W-1:0]  adj_s3_r [N_ELEM];
  logic signed [ADJ_W-1:0]  adj_s4_r [N_ELEM];
  logic signed [ADJ_W-1:0]  ph_r [3];
  logic signed [ADJ_W-1:0]  pl_r [3];
  logic        [DET_W-1:0]  det_r;
  logic        [DET_W-1:0]  det_nxt;

  logic [DIV_W-1:0] num_r [N_ELEM];
  logic [DIV_W-1:0] den_r;
  side_t            side_r;
  logic [DIV_W-1:0] num_nxt [N_ELEM];
  logic [DIV_W-1:0] den_nxt;
  logic [DIV_W-1:0] eps_sh;
  logic [DET_W-1:0] mag;

  logic [QUO_W-1:0] quo [N_ELEM];
  side_t            side_q;

  logic             out_tvalid_r;
  logic [287:0]     out_tdata_r, out_tdata_nxt;
  logic [1:0]       out_tuser_r, out_tuser_nxt;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_W'(1);
    end else if (cfg_wr_en) begin
      eps_r <= cfg_wr_data;
    end
  end

  always_comb begin
    for (int k = 0; k < N_ELEM; k++) begin
      e[k] = $signed(in_tdata[ELEM_W*k +: ELEM_W]);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      side_r.valid <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      v1_r         <= in_tvalid;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      v4_r         <= v3_r;
      side_r.valid <= v4_r;
      out_tvalid_r <= side_q.valid;
    end
  end

  // stage 1: the eighteen products of the 2x2 minors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N_ELEM; k++) begin
        prod_r[2*k]   <= e[ADJ_IDX[k][0]] * e[ADJ_IDX[k][1]];
        prod_r[2*k+1] <= e[ADJ_IDX[k][2]] * e[ADJ_IDX[k][3]];
      end
      for (int j = 0; j < 3; j++) begin
        row_s1_r[j] <= e[j];
      end
    end
  end

  // stage 2: adjugate entries
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N_ELEM; k++) begin
        adj_s2_r[k] <= {prod_r[2*k][PROD_W-1], prod_r[2*k]}
                     - {prod_r[2*k+1][PROD_W-1], prod_r[2*k+1]};
      end
      row_s2_r <= row_s1_r;
    end
  end

  // stage 3: first-row terms, each split into high and low partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        ph_r[j] <= row_s2_r[j] * $signed(adj_s2_r[COF_IDX[j]][ADJ_W-1:ELEM_W]);
        pl_r[j] <= row_s2_r[j] * $signed({1'b0, adj_s2_r[COF_IDX[j]][ELEM_W-1:0]});
      end
      adj_s3_r <= adj_s2_r;
    end
  end

  // stage 4: determinant
  always_comb begin
    det_nxt = '0;
    for (int j = 0; j < 3; j++) begin
      det_nxt = det_nxt
              + {{(DET_W-ADJ_W-ELEM_W){ph_r[j][ADJ_W-1]}}, ph_r[j], {ELEM_W{1'b0}}}
              + {{(DET_W-ADJ_W){pl_r[j][ADJ_W-1]}}, pl_r[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r    <= det_nxt;
      adj_s4_r <= adj_s3_r;
    end
  end

  // stage 5: magnitudes, threshold test and result signs
  always_comb begin
    mag     = det_r[DET_W-1] ? (~det_r + DET_W'(1)) : det_r;
    den_nxt = {{(DIV_W-DET_W){1'b0}}, mag};
    eps_sh  = {{(DIV_W-EPS_W){1'b0}}, eps_r} << (2*FRAC_BITS);
    for (int k = 0; k < N_ELEM; k++) begin
      num_nxt[k] = {{(DIV_W-ADJ_W){1'b0}},
                    adj_s4_r[k][ADJ_W-1] ? (~adj_s4_r[k] + ADJ_W'(1)) : adj_s4_r[k]}
                   << (2*FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r           <= num_nxt;
      den_r           <= den_nxt;
      side_r.singular <= (den_nxt <= eps_sh);
      for (int k = 0; k < N_ELEM; k++) begin
        side_r.neg[k] <= adj_s4_r[k][ADJ_W-1] ^ det_r[DET_W-1];
      end
    end
  end

  m3i_divider u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .num_i  (num_r),
    .den_i  (den_r),
    .side_i (side_r),
    .quo_o  (quo),
    .side_o (side_q)
  );

  // output stage: saturation and singular override
  always_comb begin
    out_tdata_nxt = '0;
    out_tuser_nxt = 2'b00;
    if (side_q.singular) begin
      out_tuser_nxt[0] = 1'b1;
    end else begin
      for (int k = 0; k < N_ELEM; k++) begin
        if (side_q.neg[k]) begin
          if (quo[k] > QUO_NEG_MAX) begin
            out_tdata_nxt[ELEM_W*k +: ELEM_W] = SAT_NEG;
            out_tuser_nxt[1] = 1'b1;
          end else begin
            out_tdata_nxt[ELEM_W*k +: ELEM_W] = ~quo[k][ELEM_W-1:0] + ELEM_W'(1);
          end
        end else begin
          if (quo[k] > QUO_POS_MAX) begin
            out_tdata_nxt[ELEM_W*k +: ELEM_W] = SAT_POS;
            out_tuser_nxt[1] = 1'b1;
          end else begin
            out_tdata_nxt[ELEM_W*k +: ELEM_W] = quo[k][ELEM_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTH
  logic any_clip;
  always_comb begin
    any_clip = 1'b0;
    for (int k = 0; k < N_ELEM; k++) begin
      if (out_tdata[ELEM_W*k +: ELEM_W] == SAT_POS ||
          out_tdata[ELEM_W*k +: ELEM_W] == SAT_NEG) begin
        any_clip = 1'b1;
      end
    end
  end

  // a singular result is all zeros and never flagged as clipped
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata == '0) && !out_tuser[1])
    else $error("singular result not cleared");

  // the clip flag always has a clipped element behind it
  a_clip_seen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> any_clip)
    else $error("saturated flag without clipped element");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
`endif

endmodule
